[src/scp_pkg.sv]
// Shared types, widths and codes for the S-curve position profile block.
// No dependencies; every other source file imports this package.
package scp_pkg;

  localparam int TIME_BITS     = 19;
  localparam int POS_FRAC_BITS = 16;
  localparam int POS_BITS      = 41;
  localparam int JERK_BITS     = 48;
  localparam int DUR_BITS      = 16;
  localparam int NUM_SEG       = 7;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 48;
  localparam int BND_BITS      = 19;
  localparam int CMP_BITS      = (TIME_BITS > BND_BITS) ? TIME_BITS : BND_BITS;
  localparam int VEL_BITS      = 40;
  localparam int K2_BITS       = 20;
  localparam int POLY_BITS     = 64;
  localparam int RND_SH        = JERK_BITS - POS_FRAC_BITS;
  localparam int PROD_BITS     = 112;
  localparam int Q_BITS        = PROD_BITS - RND_SH - 1;
  localparam int CHUNK_BITS    = 21;
  localparam int DIV_SH        = 24;
  localparam logic [DIV_SH-1:0] DIV3_RECIP = DIV_SH'((64'd1 << DIV_SH) / 3);
  localparam int SETTLE_BITS   = 4;
  localparam logic [SETTLE_BITS-1:0] SETTLE_CYCLES = '1;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = 2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_DUR1 = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUR2 = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUR3 = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUR4 = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUR5 = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUR6 = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUR7 = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_JERK = 4'd7;

  // segment codes
  localparam logic [2:0] SEG1 = 3'd1;
  localparam logic [2:0] SEG2 = 3'd2;
  localparam logic [2:0] SEG3 = 3'd3;
  localparam logic [2:0] SEG4 = 3'd4;
  localparam logic [2:0] SEG5 = 3'd5;
  localparam logic [2:0] SEG6 = 3'd6;
  localparam logic [2:0] SEG7 = 3'd7;
  localparam logic [NUM_SEG-1:0][2:0] SEG_OF = {SEG7, SEG6, SEG5, SEG4, SEG3, SEG2, SEG1};

  // sign of the cubic term
  localparam logic [1:0] CUBE_NONE = 2'd0;
  localparam logic [1:0] CUBE_POS  = 2'd1;
  localparam logic [1:0] CUBE_NEG  = 2'd2;

  typedef struct packed {
    logic [NUM_SEG-1:0][BND_BITS-1:0] bnd;
    logic signed [JERK_BITS-1:0]      jerk;
    logic signed [POLY_BITS-1:0]      k0_t1c;
    logic signed [POLY_BITS-1:0]      k0_a;
    logic signed [POLY_BITS-1:0]      k0_b;
    logic signed [POLY_BITS-1:0]      k0_c;
    logic signed [POLY_BITS-1:0]      k0_d;
    logic signed [POLY_BITS-1:0]      k0_e;
    logic signed [VEL_BITS-1:0]       v2;
    logic signed [VEL_BITS-1:0]       v4;
    logic signed [VEL_BITS-1:0]       v6;
    logic signed [VEL_BITS-1:0]       v7;
    logic signed [K2_BITS-1:0]        k2_acc;
    logic signed [K2_BITS-1:0]        k2_dec;
  } coeff_t;

  typedef struct packed {
    logic [2:0]          seg;
    logic [DUR_BITS-1:0] u;
    logic                in_range;
  } item_t;

endpackage

[src/scp_coeff.sv]
// Configuration registers and the derived profile coefficients.
// Depends on scp_pkg.
module scp_coeff (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [scp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [scp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output scp_pkg::coeff_t                    coeff,
  output logic                               busy
);
  import scp_pkg::*;

  logic [NUM_SEG-1:0][DUR_BITS-1:0] dur;
  logic [JERK_BITS-1:0]             jerk;
  logic [SETTLE_BITS-1:0]           settle;

  logic [NUM_SEG-1:0][BND_BITS-1:0] bnd_sum;
  logic [31:0] t1t1, t1t2, t1t3, t2t2, t3t3, t5t5, t5t6, t6t6;
  logic [47:0] t1_cube, t1t1t2, t1t2t2, t3_cube, t1t3t3, t5_cube, t5t6t6;
  logic signed [POLY_BITS-1:0] v4t4, v4t5, v6t6;

  function automatic logic [VEL_BITS-1:0] ext_v(input logic [31:0] x);
    ext_v = {{(VEL_BITS-32){1'b0}}, x};
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (settle != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dur  <= '0;
      jerk <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DUR1: dur[0] <= cfg_data[DUR_BITS-1:0];
        REG_DUR2: dur[1] <= cfg_data[DUR_BITS-1:0];
        REG_DUR3: dur[2] <= cfg_data[DUR_BITS-1:0];
        REG_DUR4: dur[3] <= cfg_data[DUR_BITS-1:0];
        REG_DUR5: dur[4] <= cfg_data[DUR_BITS-1:0];
        REG_DUR6: dur[5] <= cfg_data[DUR_BITS-1:0];
        REG_DUR7: dur[6] <= cfg_data[DUR_BITS-1:0];
        REG_JERK: jerk   <= cfg_data[JERK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // hold off items until the coefficient pipe has flushed
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE_CYCLES;
    end else if (cfg_valid) begin
      settle <= SETTLE_CYCLES;
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  always_comb begin
    bnd_sum[0] = BND_BITS'(dur[0]);
    for (int k = 1; k < NUM_SEG; k++) begin
      bnd_sum[k] = bnd_sum[k-1] + BND_BITS'(dur[k]);
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: squares and boundaries
    coeff.bnd    <= bnd_sum;
    coeff.jerk   <= $signed(jerk);
    t1t1 <= dur[0] * dur[0];
    t1t2 <= dur[0] * dur[1];
    t1t3 <= dur[0] * dur[2];
    t2t2 <= dur[1] * dur[1];
    t3t3 <= dur[2] * dur[2];
    t5t5 <= dur[4] * dur[4];
    t5t6 <= dur[4] * dur[5];
    t6t6 <= dur[5] * dur[5];
    coeff.k2_acc <= $signed(K2_BITS'(dur[0]) * K2_BITS'(3));
    coeff.k2_dec <= $signed(K2_BITS'(0) - K2_BITS'(dur[4]) * K2_BITS'(3));
    // stage 2: cubes
    t1_cube <= t1t1 * dur[0];
    t1t1t2  <= t1t1 * dur[1];
    t1t2t2  <= t2t2 * dur[0];
    t3_cube <= t3t3 * dur[2];
    t1t3t3  <= t3t3 * dur[0];
    t5_cube <= t5t5 * dur[4];
    t5t6t6  <= t6t6 * dur[4];
    coeff.v2 <= $signed(ext_v(t1t1) * VEL_BITS'(3));
    coeff.v4 <= $signed(ext_v(t1t1) * VEL_BITS'(3) + ext_v(t1t2) * VEL_BITS'(6)
                + ext_v(t1t3) * VEL_BITS'(6) - ext_v(t3t3) * VEL_BITS'(3));
    coeff.k0_t1c <= $signed(POLY_BITS'(t1_cube));
    // stage 3
    coeff.k0_a <= $signed(POLY_BITS'(t1t1t2) * POLY_BITS'(3)
                  + POLY_BITS'(t1t2t2) * POLY_BITS'(3) + POLY_BITS'(t1_cube));
    coeff.v6   <= coeff.v4 - $signed(ext_v(t5t5) * VEL_BITS'(3));
    v4t4       <= coeff.v4 * $signed({1'b0, dur[3]});
    // stage 4
    coeff.k0_b <= coeff.k0_a + $signed(POLY_BITS'(t1t3t3) * POLY_BITS'(3))
                  - $signed(POLY_BITS'(t3_cube));
    v4t5       <= coeff.v4 * $signed({1'b0, dur[4]});
    v6t6       <= coeff.v6 * $signed({1'b0, dur[5]});
    coeff.v7   <= coeff.v6 - $signed(ext_v(t5t6) * VEL_BITS'(6));
    // stages 5 to 7
    coeff.k0_c <= coeff.k0_b + v4t4;
    coeff.k0_d <= coeff.k0_c + v4t5 - $signed(POLY_BITS'(t5_cube));
    coeff.k0_e <= coeff.k0_d + v6t6 - $signed(POLY_BITS'(t5t6t6) * POLY_BITS'(3));
  end

endmodule

[src/scp_front.sv]
// Front end: takes time samples, picks the segment and the local time.
// Depends on scp_pkg.
module scp_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [scp_pkg::TIME_BITS-1:0]  time_now,
  input  logic                           busy,
  input  scp_pkg::coeff_t                coeff,
  input  logic                           q_full,
  output logic                           push,
  output scp_pkg::item_t                 push_item
);
  import scp_pkg::*;

  logic                 f_valid;
  logic [TIME_BITS-1:0] f_t;
  logic                 f_adv;
  logic                 accept;
  logic [CMP_BITS-1:0]  t_ext;
  logic [NUM_SEG-1:0][CMP_BITS-1:0] lo;
  logic [CMP_BITS-1:0]  start;

  assign f_adv    = !f_valid || !q_full;
  assign in_stall = busy || !f_adv;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_adv) begin
      f_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_t <= time_now;
    end
  end

  // lowest segment whose end lies above t wins, else segment seven; empty segments below seven never match
  always_comb begin
    t_ext = CMP_BITS'(f_t);
    lo[0] = '0;
    for (int k = 1; k < NUM_SEG; k++) begin
      lo[k] = CMP_BITS'(coeff.bnd[k-1]);
    end
    push_item.seg = SEG7;
    start         = lo[NUM_SEG-1];
    for (int k = NUM_SEG - 2; k >= 0; k--) begin
      if (t_ext < CMP_BITS'(coeff.bnd[k])) begin
        push_item.seg = SEG_OF[k];
        start         = lo[k];
      end
    end
    push_item.in_range = (t_ext <= CMP_BITS'(coeff.bnd[NUM_SEG-1]));
    push_item.u        = DUR_BITS'(t_ext - start);
  end

endmodule

[src/scp_queue.sv]
// Short request queue between the front end and the evaluator.
// Depends on scp_pkg.
module scp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output scp_pkg::item_t pop_item,
  output logic           empty
);
  import scp_pkg::*;

  item_t                entry [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp;
  logic [QPTR_BITS-1:0] rp;
  logic [QPTR_BITS:0]   cnt;

  assign full     = (cnt == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty    = (cnt == '0);
  assign pop_item = entry[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= push_item;
    end
  end

endmodule

[src/scp_back.sv]
// Back end: evaluates the segment cubic, scales by jerk, rounds and clips.
// Depends on scp_pkg.
module scp_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  scp_pkg::coeff_t                       coeff,
  input  logic                                  q_empty,
  input  scp_pkg::item_t                        q_item,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [scp_pkg::POS_BITS-1:0]   position,
  output logic                                  in_range,
  output logic                                  saturated
);
  import scp_pkg::*;

  localparam int NSTG = 11;
  localparam logic [Q_BITS-1:0] SAT_POS_Q = Q_BITS'(3) << (POS_BITS - 1);
  localparam logic [Q_BITS-1:0] SAT_NEG_Q = SAT_POS_Q + Q_BITS'(3);
  localparam logic [PROD_BITS-1:0] RND_ADD = PROD_BITS'(3) << RND_SH;
  localparam logic [POS_BITS:0] LIM_NEG = (POS_BITS+1)'(1) << (POS_BITS - 1);
  localparam logic [POS_BITS:0] LIM_POS = LIM_NEG - 1'b1;

  logic             en;
  logic [NSTG:1]    v;
  logic [NSTG-1:1]  inr;
  logic [NSTG-1:5]  neg;

  logic [DUR_BITS-1:0]          u1, u2r;
  logic signed [POLY_BITS-1:0]  k0_1, k0_2, k0_3;
  logic signed [VEL_BITS-1:0]   k1_1, k1_2;
  logic signed [K2_BITS-1:0]    k2_1, k2_2;
  logic [1:0]                   c3_1, c3_2, c3_3;
  logic signed [POLY_BITS-1:0]  k0_sel;
  logic signed [VEL_BITS-1:0]   k1_sel;
  logic signed [K2_BITS-1:0]    k2_sel;
  logic [1:0]                   c3_sel;
  logic [31:0]                  usq;
  logic [47:0]                  ucube;
  logic signed [POLY_BITS-1:0]  k1u, k2u2, cube_term, p;
  logic [POLY_BITS-1:0]         pmag;
  logic [JERK_BITS-1:0]         jmag;
  logic [63:0]                  pp00, pp01;
  logic [47:0]                  pp10, pp11;
  logic [PROD_BITS-1:0]         prod;
  logic [Q_BITS-1:0]            q;
  logic [9:8]                   sat;
  logic [CHUNK_BITS-1:0]        qh, qh3, qh3_r, qh3_rr;
  logic [CHUNK_BITS-1:0]        ql;
  logic [CHUNK_BITS+DIV_SH-1:0] qh_prod;
  logic [CHUNK_BITS-1:0]        qh_est;
  logic [CHUNK_BITS+1:0]        qh_rem;
  logic [CHUNK_BITS+1:0]        x, x_r, x_rr;
  logic [CHUNK_BITS+1+DIV_SH:0] x_prod;
  logic [CHUNK_BITS+1:0]        x_est, x_rem;
  logic [CHUNK_BITS-1:0]        x3;
  logic [POS_BITS:0]            mag, lim;
  logic [10:10]                 sat10;

  // whole evaluator advances unless a finished result is held
  assign en        = !(v[NSTG] && out_stall);
  assign pop       = en && !q_empty;
  assign out_valid = v[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NSTG-1:1], pop};
    end
  end

  always_comb begin
    case (q_item.seg)
      SEG1: begin k0_sel = '0; k1_sel = '0; k2_sel = '0; c3_sel = CUBE_POS; end
      SEG2: begin
        k0_sel = coeff.k0_t1c; k1_sel = coeff.v2; k2_sel = coeff.k2_acc; c3_sel = CUBE_NONE;
      end
      SEG3: begin
        k0_sel = coeff.k0_a; k1_sel = '0; k2_sel = coeff.k2_acc; c3_sel = CUBE_NEG;
      end
      SEG4: begin k0_sel = coeff.k0_b; k1_sel = coeff.v4; k2_sel = '0; c3_sel = CUBE_NONE; end
      SEG5: begin k0_sel = coeff.k0_c; k1_sel = coeff.v4; k2_sel = '0; c3_sel = CUBE_NEG; end
      SEG6: begin
        k0_sel = coeff.k0_d; k1_sel = coeff.v6; k2_sel = coeff.k2_dec; c3_sel = CUBE_NONE;
      end
      default: begin
        k0_sel = coeff.k0_e; k1_sel = coeff.v7; k2_sel = coeff.k2_dec; c3_sel = CUBE_POS;
      end
    endcase
  end

  always_comb begin
    case (c3_3)
      CUBE_POS: cube_term = $signed(POLY_BITS'(ucube));
      CUBE_NEG: cube_term = $signed(POLY_BITS'(0) - POLY_BITS'(ucube));
      default:  cube_term = '0;
    endcase
  end

  assign q      = Q_BITS'(prod >> (RND_SH + 1));
  assign qh_est = CHUNK_BITS'(qh_prod >> DIV_SH);
  assign qh_rem = (CHUNK_BITS+2)'(qh) - (CHUNK_BITS+2)'(qh_est) * (CHUNK_BITS+2)'(3);
  assign x_est  = (CHUNK_BITS+2)'(x_prod >> DIV_SH);
  assign x_rem  = x_rr - x_est * (CHUNK_BITS+2)'(3);
  assign x3     = (x_rem >= (CHUNK_BITS+2)'(3)) ? CHUNK_BITS'(x_est + 1'b1)
                                                : CHUNK_BITS'(x_est);
  assign mag    = {qh3_rr, x3};
  assign lim    = neg[10] ? LIM_NEG : LIM_POS;

  always_comb begin
    if (qh_rem >= (CHUNK_BITS+2)'(3)) begin
      qh3 = qh_est + 1'b1;
      x   = {qh_rem[1:0] - 2'd3, ql};
    end else begin
      qh3 = qh_est;
      x   = {qh_rem[1:0], ql};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // 1: coefficient select
      u1 <= q_item.u; inr[1] <= q_item.in_range;
      k0_1 <= k0_sel; k1_1 <= k1_sel; k2_1 <= k2_sel; c3_1 <= c3_sel;
      // 2: square
      usq <= u1 * u1; u2r <= u1; inr[2] <= inr[1];
      k0_2 <= k0_1; k1_2 <= k1_1; k2_2 <= k2_1; c3_2 <= c3_1;
      // 3: cube and scaled terms
      ucube <= usq * u2r;
      k1u   <= k1_2 * $signed({1'b0, u2r});
      k2u2  <= k2_2 * $signed({1'b0, usq});
      k0_3  <= k0_2; c3_3 <= c3_2; inr[3] <= inr[2];
      // 4: sum the cubic
      p <= k0_3 + k1u + k2u2 + cube_term; inr[4] <= inr[3];
      // 5: magnitudes
      neg[5] <= coeff.jerk[JERK_BITS-1] ^ p[POLY_BITS-1];
      pmag   <= p[POLY_BITS-1] ? POLY_BITS'(0) - p : p;
      jmag   <= coeff.jerk[JERK_BITS-1] ? JERK_BITS'(0) - coeff.jerk : coeff.jerk;
      inr[5] <= inr[4];
      // 6: partial products
      pp00 <= jmag[31:0] * pmag[31:0];
      pp01 <= jmag[31:0] * pmag[63:32];
      pp10 <= jmag[47:32] * pmag[31:0];
      pp11 <= jmag[47:32] * pmag[63:32];
      neg[6] <= neg[5]; inr[6] <= inr[5];
      // 7: full product with rounding offset
      prod <= PROD_BITS'(pp00) + (PROD_BITS'(pp01) << 32) + (PROD_BITS'(pp10) << 32)
              + (PROD_BITS'(pp11) << 64) + RND_ADD;
      neg[7] <= neg[6]; inr[7] <= inr[6];
      // 8: clip test, divide high chunk by three
      sat[8]  <= neg[7] ? (q >= SAT_NEG_Q) : (q >= SAT_POS_Q);
      qh      <= q[2*CHUNK_BITS-1:CHUNK_BITS];
      ql      <= q[CHUNK_BITS-1:0];
      qh_prod <= q[2*CHUNK_BITS-1:CHUNK_BITS] * DIV3_RECIP;
      neg[8]  <= neg[7]; inr[8] <= inr[7];
      // 9: correct high quotient, fold remainder into low chunk
      qh3_r  <= qh3; x_r <= x; sat[9] <= sat[8];
      neg[9] <= neg[8]; inr[9] <= inr[8];
      // 10: divide low chunk by three; carry the chunks alongside
      x_prod  <= x_r * DIV3_RECIP;
      qh3_rr  <= qh3_r; x_rr <= x_r;
      sat10   <= sat[9];
      neg[10] <= neg[9]; inr[10] <= inr[9];
      // 11: combine, clip, sign
      if (!inr[10]) begin
        position  <= '0;
        saturated <= 1'b0;
      end else if (sat10[10]) begin
        position  <= POS_BITS'(neg[10] ? (POS_BITS+1)'(0) - lim : lim);
        saturated <= 1'b1;
      end else begin
        position  <= POS_BITS'(neg[10] ? (POS_BITS+1)'(0) - mag : mag);
        saturated <= 1'b0;
      end
      in_range <= inr[10];
    end
  end

endmodule

[src/s_curve_position_profile.sv]
// S-curve position profile evaluator: seven-segment jerk-limited position at a time tick.
// Throughput: one request per cycle while neither in_stall nor out_stall holds the flow;
// the evaluator pipeline runs one sample per stage.
// After reset, and after each register write, in_stall stays high while the coefficient
// pipeline settles; registers reset to zero.
// Depends on scp_pkg, scp_coeff, scp_front, scp_queue and scp_back.
module s_curve_position_profile (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [scp_pkg::TIME_BITS-1:0]         time_now,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [scp_pkg::POS_BITS-1:0]   position,
  output logic                                  in_range,
  output logic                                  saturated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [scp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [scp_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import scp_pkg::*;

  coeff_t coeff;
  logic   busy;
  logic   push, pop, q_full, q_empty;
  item_t  push_item, pop_item;

  // registers plus boundaries and polynomial constants derived from them
  scp_coeff u_coeff (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coeff     (coeff),
    .busy      (busy)
  );

  // classify each request into its segment and local time
  scp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .time_now  (time_now),
    .busy      (busy),
    .coeff     (coeff),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // decouple the front from a stalled output
  scp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // evaluate, scale by jerk, round, clip; the last stage is the output register
  scp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .coeff     (coeff),
    .q_empty   (q_empty),
    .q_item    (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .position  (position),
    .in_range  (in_range),
    .saturated (saturated)
  );

endmodule
